@@ rtl/u2l_pkg.sv @@
`timescale 1ns / 1ps

package u2l_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PointW = 21;
  localparam int unsigned CountW = 2;

  // Lead byte patterns
  localparam logic [4:0] Lead4Pat = 5'b11110;
  localparam logic [3:0] Lead3Pat = 4'b1110;
  localparam logic [2:0] Lead2Pat = 3'b110;
  localparam logic [1:0] LeadTag  = 2'b11;

  localparam logic [PointW-1:0] Latin1Max = PointW'(8'hFF);

  typedef struct packed {
    logic             out_valid;
    logic [ByteW-1:0] out_byte;
    logic             halted;
  } dec_res_t;

endpackage

@@ rtl/u2l_in_if.sv @@
`timescale 1ns / 1ps

interface u2l_in_if;
  import u2l_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface u2l_out_if;
  import u2l_pkg::*;

  logic             valid;
  logic             ready;
  logic             out_valid;
  logic [ByteW-1:0] out_byte;
  logic             halted;

  modport source (output valid, output out_valid, output out_byte, output halted,
                  input ready);
  modport sink (input valid, input out_valid, input out_byte, input halted,
                output ready);
endinterface

@@ rtl/u2l_in_stage.sv @@
`timescale 1ns / 1ps

module u2l_in_stage import u2l_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  u2l_in_if.sink           in_i,
  input  logic             take_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.in_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ rtl/u2l_decode.sv @@
`timescale 1ns / 1ps

module u2l_decode import u2l_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  output dec_res_t         res_o
);

  logic [CountW-1:0] pend_q, pend_d;
  logic [PointW-1:0] point_q, point_d;
  logic              stop_q, stop_d;
  logic [PointW-1:0] shifted;
  logic [CountW-1:0] pend_dec;

  assign shifted  = {point_q[PointW-7:0], byte_i[5:0]};
  assign pend_dec = pend_q - CountW'(1);

  always_comb begin
    pend_d          = pend_q;
    point_d         = point_q;
    stop_d          = stop_q;
    res_o.out_valid = 1'b0;
    res_o.out_byte  = '0;
    priority if (byte_i == '0) begin
      pend_d  = '0;
      point_d = '0;
      stop_d  = 1'b0;
    end else if (stop_q) begin
      // halted: drop everything until the string ends
    end else if (!byte_i[7]) begin
      res_o.out_valid = 1'b1;
      res_o.out_byte  = byte_i;
    end else if (byte_i[7:6] == LeadTag) begin
      priority if (pend_q != '0) begin
        stop_d = 1'b1;
      end else if (byte_i[7:3] == Lead4Pat) begin
        point_d = PointW'(byte_i[2:0]);
        pend_d  = CountW'(3);
      end else if (byte_i[7:4] == Lead3Pat) begin
        point_d = PointW'(byte_i[3:0]);
        pend_d  = CountW'(2);
      end else if (byte_i[7:5] == Lead2Pat) begin
        point_d = PointW'(byte_i[4:0]);
        pend_d  = CountW'(1);
      end else begin
        stop_d = 1'b1;
      end
    end else if (pend_q != '0) begin
      pend_d = pend_dec;
      if (pend_dec == '0) begin
        point_d = '0;
        if (shifted <= Latin1Max) begin
          res_o.out_valid = 1'b1;
          res_o.out_byte  = shifted[ByteW-1:0];
        end
      end else begin
        point_d = shifted;
      end
    end else begin
      // stray continuation with nothing pending: drop it, hold state
    end
    res_o.halted = stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      point_q <= '0;
      stop_q  <= 1'b0;
    end else if (fire_i) begin
      pend_q  <= pend_d;
      point_q <= point_d;
      stop_q  <= stop_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_valid_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> !(res_o.out_valid && res_o.halted))
    else $error("character emitted while halted");

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && byte_i == '0) |=> (pend_q == '0 && point_q == '0 && !stop_q))
    else $error("terminator did not clear state");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && stop_q && byte_i != '0) |=> stop_q)
    else $error("halt released without terminator");
`endif

endmodule

@@ rtl/u2l_out_stage.sv @@
`timescale 1ns / 1ps

module u2l_out_stage import u2l_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  dec_res_t res_i,
  output logic     ready_o,
  u2l_out_if.source out_o
);

  logic     valid_q, valid_d;
  dec_res_t res_q;
  logic     load;

  assign ready_o = !valid_q || out_o.ready;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_valid = res_q.out_valid;
  assign out_o.out_byte  = res_q.out_byte;
  assign out_o.halted    = res_q.halted;

endmodule

@@ rtl/utf8_to_latin1_filter_unit.sv @@
`timescale 1ns / 1ps

// UTF-8 to Latin-1 filter. Feed one UTF-8 byte per transaction on in_i;
// every input transaction yields exactly one transaction on out_o carrying
// out_valid (a Latin-1 character is present), out_byte and halted.
// ASCII passes straight through; multi-byte sequences are assembled and
// emitted on their last continuation byte if the code point fits in 8 bits.
// A bad lead byte halts conversion until a zero byte ends the string.
// Path: an accepted byte is held in the input register; when the output
// register is free, its result is loaded there and is offered on out_o
// until taken. Throughput: one byte per cycle while out_o keeps ready
// high; the decoder state commits straight from the input register when
// a byte moves on, so only receiver stalls hold the rate below one per clock.
// Reset (rst_ni low, asynchronous) empties both registers and clears the
// pending count, partial code point and halt flag.
// When the receiver stalls, the result holds in the output register and
// one more byte can still be taken into the input register; after that
// in_i.ready drops until out_o moves again.
module utf8_to_latin1_filter_unit import u2l_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2l_in_if.sink    in_i,
  u2l_out_if.source out_o
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s2_ready;
  logic             fire;
  dec_res_t         dec_res;

  // Advance the input register into the decoder when the result slot frees.
  assign fire = s1_valid && s2_ready;

  u2l_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (fire),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  // Decoder state commits only on fire, so stalls never double-count a byte.
  u2l_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s1_byte),
    .res_o  (dec_res)
  );

  u2l_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .res_i   (dec_res),
    .ready_o (s2_ready),
    .out_o   (out_o)
  );

endmodule

@@ bench/tb_utf8_to_latin1_filter_unit.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the UTF-8 to Latin-1 filter.
module tb_utf8_to_latin1_filter_unit;
  import u2l_pkg::*;

  // Directed rows either carry a result typed in by hand, or defer to the decoder below.
  localparam bit FIXED = 1'b1;
  localparam bit PRED  = 1'b0;

  localparam int unsigned RandBytes   = 1200;
  localparam int unsigned PauseAt     = 600;  // sender drains the pipe once here
  localparam int unsigned QuietFrom   = 1000; // no idling on either side from here on
  localparam int unsigned DrainCycles = 8;

  localparam dec_res_t NoChar  = '0;
  localparam dec_res_t Stopped = {1'b0, 8'h00, 1'b1};

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             fixed;
    dec_res_t         want;
  } dir_row_t;

  localparam int unsigned DirRows = 28;

  dir_row_t dir_rows [DirRows] = '{
    '{8'h7F, FIXED, {1'b1, 8'h7F, 1'b0}},        // top ASCII right after reset
    '{8'h00, FIXED, NoChar},                     // zero byte ends the string
    '{8'h80, FIXED, NoChar},                     // continuation with nothing pending
    '{8'hC3, PRED,  NoChar},                     // two-byte sequence, U+00E9
    '{8'hA9, PRED,  NoChar},
    '{8'hC4, PRED,  NoChar},                     // U+0100 does not fit, dropped
    '{8'h80, PRED,  NoChar},
    '{8'hE0, PRED,  NoChar},                     // three-byte sequence that fits
    '{8'h82, PRED,  NoChar},
    '{8'hBF, PRED,  NoChar},
    '{8'hF0, PRED,  NoChar},                     // four-byte sequence, ends at 0xFF
    '{8'h80, PRED,  NoChar},
    '{8'h83, PRED,  NoChar},
    '{8'hBF, PRED,  NoChar},
    '{8'hF7, PRED,  NoChar},                     // largest code point, dropped
    '{8'hBF, PRED,  NoChar},
    '{8'hBF, PRED,  NoChar},
    '{8'hBF, PRED,  NoChar},
    '{8'hC3, PRED,  NoChar},                     // ASCII in the middle of a sequence
    '{8'h41, FIXED, {1'b1, 8'h41, 1'b0}},
    '{8'hBF, PRED,  NoChar},
    '{8'hC3, PRED,  NoChar},                     // lead while a sequence is pending
    '{8'hC3, FIXED, Stopped},
    '{8'h41, FIXED, Stopped},                    // halted: ASCII ignored
    '{8'h00, FIXED, NoChar},
    '{8'hF8, FIXED, Stopped},                    // invalid lead
    '{8'hFF, FIXED, Stopped},
    '{8'h00, FIXED, NoChar}
  };

  logic clk_i;
  logic rst_ni;

  u2l_in_if  in_if ();
  u2l_out_if out_if ();

  utf8_to_latin1_filter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder state kept by the bench.
  logic [CountW-1:0] seq_left;
  logic [PointW-1:0] code_acc;
  logic              conv_stopped;

  dec_res_t    expected_q [$];
  int unsigned fail_count;
  int unsigned bytes_sent;
  bit          idle_en;
  int unsigned stall_left;

  // Advance the decoder by one byte and return the result it should produce.
  function automatic dec_res_t decode_byte(input logic [ByteW-1:0] b);
    dec_res_t r;
    r = '0;
    if (b == '0) begin
      seq_left     = '0;
      code_acc     = '0;
      conv_stopped = 1'b0;
    end else if (conv_stopped) begin
      // hold everything until the string ends
    end else if (!b[7]) begin
      r.out_valid = 1'b1;
      r.out_byte  = b;
    end else if (b[7:6] == LeadTag) begin
      if (seq_left != '0) begin
        conv_stopped = 1'b1;
      end else if (b[7:3] == Lead4Pat) begin
        code_acc = PointW'(b[2:0]);
        seq_left = 2'd3;
      end else if (b[7:4] == Lead3Pat) begin
        code_acc = PointW'(b[3:0]);
        seq_left = 2'd2;
      end else if (b[7:5] == Lead2Pat) begin
        code_acc = PointW'(b[4:0]);
        seq_left = 2'd1;
      end else begin
        conv_stopped = 1'b1;
      end
    end else if (seq_left != '0) begin
      // Shift in six payload bits; the top bits fall off at the point width.
      code_acc = {code_acc[PointW-7:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == '0) begin
        if (code_acc <= Latin1Max) begin
          r.out_valid = 1'b1;
          r.out_byte  = code_acc[ByteW-1:0];
        end
        code_acc = '0;
      end
    end
    r.halted = conv_stopped;
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the pipe hangs.
  initial begin
    #5_000_000;
    $display("utf8_to_latin1_filter_unit verification failed");
    $finish;
  end

  // Receiver: drop ready for bursts of random length while idling is on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 14);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic flag_field(input string what, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // Check each result transaction against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dec_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, got valid=%0d byte=0x%0h halted=%0d",
                 $time, out_if.out_valid, out_if.out_byte, out_if.halted);
      end else begin
        want = expected_q.pop_front();
        flag_field("out_valid", want.out_valid, out_if.out_valid);
        flag_field("out_byte", want.out_byte, out_if.out_byte);
        flag_field("halted", want.halted, out_if.halted);
      end
    end
  end

  // Offer one byte and hold it until the filter takes it. Call just after a rising edge.
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic feed_byte(input logic [ByteW-1:0] b);
    send_byte(b);
    expected_q.push_back(decode_byte(b));
  endtask

  function automatic logic [ByteW-1:0] rand_ascii();
    return ByteW'($urandom_range(1, 127));
  endfunction

  // Continuation byte, now and then preceded by ASCII that should slip through.
  task automatic feed_cont();
    if ($urandom_range(0, 19) == 0) feed_byte(rand_ascii());
    feed_byte({2'b10, 6'($urandom_range(0, 63))});
  endtask

  function automatic logic [ByteW-1:0] rand_lead();
    case ($urandom_range(0, 2))
      0:       return {Lead2Pat, 5'($urandom_range(0, 31))};
      1:       return {Lead3Pat, 4'($urandom_range(0, 15))};
      default: return {Lead4Pat, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  // One random chunk of the string: mostly well-formed sequences, some breakage.
  task automatic feed_chunk();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      feed_byte(rand_ascii());
    end else if (k < 55) begin
      // Favor C2/C3 so most two-byte sequences land in Latin-1.
      if ($urandom_range(0, 1) != 0) feed_byte({Lead2Pat, 5'($urandom_range(2, 3))});
      else feed_byte({Lead2Pat, 5'($urandom_range(0, 31))});
      feed_cont();
    end else if (k < 70) begin
      if ($urandom_range(0, 1) != 0) begin
        feed_byte({Lead3Pat, 4'h0});
        feed_byte({6'b100000, 2'($urandom_range(0, 3))});
      end else begin
        feed_byte({Lead3Pat, 4'($urandom_range(0, 15))});
        feed_cont();
      end
      feed_cont();
    end else if (k < 80) begin
      if ($urandom_range(0, 1) != 0) begin
        feed_byte({Lead4Pat, 3'h0});
        feed_byte(8'h80);
        feed_byte({6'b100000, 2'($urandom_range(0, 3))});
      end else begin
        feed_byte({Lead4Pat, 3'($urandom_range(0, 7))});
        feed_cont();
        feed_cont();
      end
      feed_cont();
    end else if (k < 88) begin
      feed_byte(8'h00);
    end else if (k < 93) begin
      feed_byte({2'b10, 6'($urandom_range(0, 63))});
    end else if (k < 96) begin
      // Likely truncated: a new lead arrives, cutting short any sequence left open.
      feed_byte(rand_lead());
      if ($urandom_range(0, 1) != 0) feed_cont();
      feed_byte(rand_lead());
    end else if (k < 98) begin
      feed_byte({5'b11111, 3'($urandom_range(0, 7))});
    end else begin
      feed_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    dec_res_t    pred;
    int unsigned next_mode_at;
    bit          paused;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    seq_left      = '0;
    code_acc      = '0;
    conv_stopped  = 1'b0;
    fail_count    = 0;
    bytes_sent    = 0;
    idle_en       = 1'b1;
    stall_left    = 0;
    paused        = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; keep the decoder in step even where the result is typed in.
    for (int i = 0; i < DirRows; i++) begin
      send_byte(dir_rows[i].in_byte);
      pred = decode_byte(dir_rows[i].in_byte);
      expected_q.push_back(dir_rows[i].fixed ? dir_rows[i].want : pred);
    end

    // Random string, switching idling on and off in stretches.
    bytes_sent   = 0;
    next_mode_at = 0;
    while (bytes_sent < RandBytes) begin
      if (bytes_sent >= QuietFrom) begin
        idle_en <= 1'b0;
      end else if (bytes_sent >= next_mode_at) begin
        idle_en      <= ($urandom_range(0, 3) != 0);
        next_mode_at  = bytes_sent + $urandom_range(50, 150);
      end
      if (!paused && bytes_sent >= PauseAt) begin
        // Drain: hold off until every outstanding result has come back.
        paused = 1'b1;
        in_if.valid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk_i);
      end
      feed_chunk();
    end
    in_if.valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("utf8_to_latin1_filter_unit verification clean");
    end else begin
      $display("utf8_to_latin1_filter_unit verification failed");
    end
    $finish;
  end

endmodule
